@@ sv/assert_macros.svh @@
// Assertion macros for the port-level checker of the peak filler.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/lpf_pkg.sv @@
// Package for the lobe peak filler: widths, reset values, register codes, types.
// No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps

package lpf_pkg;

   localparam int LPF_CHANNELS = 2;

   localparam int MAG_W     = 23;
   localparam int SAMPLE_W  = 24;
   localparam int COUNT_W   = 31;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = MAG_W;

   localparam logic             SAMPLE_WIDTH_RESET = 1'b1;
   localparam logic [MAG_W-1:0] THRESHOLD_RESET    = 23'd83886;
   localparam logic [MAG_W-1:0] CLIP_LEVEL_RESET   = 23'd8371830;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_WIDTH = 2'd0,
      CSR_THRESHOLD    = 2'd1,
      CSR_CLIP_LEVEL   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic               out_channel;
      logic [MAG_W-1:0]   value;
      logic [COUNT_W-1:0] repeat_count;
      logic               last;
   } record_type;

   typedef struct packed {
      logic               in_run;
      logic               first_seen;
      logic [COUNT_W-1:0] run_length;
      logic [MAG_W-1:0]   run_peak;
   } chan_state_type;

endpackage

@@ sv/lpf_if.sv @@
// Handshake interfaces for the lobe peak filler: request, response, register write.
// Depends on lpf_pkg for field widths.
`timescale 1ns / 1ps

interface lpf_req_if import lpf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                channel;
   logic [SAMPLE_W-1:0] sample;
   logic                end_of_stream;

   modport source (output valid, channel, sample, end_of_stream, input ready);
   modport sink   (input valid, channel, sample, end_of_stream, output ready);
endinterface

interface lpf_rsp_if import lpf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               out_channel;
   logic [MAG_W-1:0]   value;
   logic [COUNT_W-1:0] repeat_count;
   logic               last;

   modport source (output valid, out_channel, value, repeat_count, last, input ready);
   modport sink   (input valid, out_channel, value, repeat_count, last, output ready);
endinterface

interface lpf_csr_if import lpf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/lobe_peak_fill.sv @@
// Lobe peak filler top level: per-channel run-to-peak replacement of PCM samples.
// Depends on lpf_pkg and the interfaces in lpf_if.sv.
//
// Usage:
//  - req_port carries one PCM sample per request: channel, signed 24-bit
//    sample (16-bit value in its low half in 16-bit mode) and end_of_stream.
//  - rsp_port carries value-and-count records; last marks the final record
//    that a request causes. A request yields zero, one or two records.
//  - csr_port writes sample_width (0), threshold (1) and clip_level (2).
//    It is always ready; write it only while no request is in flight.
//  - An accepted request is held in the input register while it is evaluated;
//    its records then go into the result queue, whose head drives rsp_port.
//  - Throughput: one request per cycle while each yields at most one record
//    and rsp_port is ready. A run that ends on a low sample yields two records,
//    which leave the single-record response port one after the other; the
//    two-entry result queue holds them.
//  - A stalled receiver fills the result queue, then the input register,
//    then req_port.ready drops. Nothing is dropped or repeated.
//  - Reset clears the channel state, the queue and loads the register
//    defaults (24-bit, threshold 83886, clip 8371830).
`timescale 1ns / 1ps

module lobe_peak_fill import lpf_pkg::*; #(
   parameter int CHANNELS = LPF_CHANNELS
) (
   input  logic      clock,
   input  logic      reset,
   lpf_req_if.sink   req_port,
   lpf_rsp_if.source rsp_port,
   lpf_csr_if.sink   csr_port
);

   // configuration registers
   logic             cfg_sw_ff;
   logic [MAG_W-1:0] cfg_thr_ff;
   logic [MAG_W-1:0] cfg_clip_ff;

   // input register
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_chan_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic                s1_eos_ff;

   // per-channel state
   chan_state_type state_ff [CHANNELS];
   chan_state_type state_in;

   // result queue, head at entry 0
   record_type recq_ff [2];
   record_type recq_in [2];
   logic [1:0] occ_ff, occ_in;

   logic             req_take;
   logic             pop;
   logic             ch_ok;
   logic             go;
   logic [SAMPLE_W:0] mag_raw;   // up to 2^23 before clipping
   logic [MAG_W-1:0] mag;
   chan_state_type   cur;
   record_type       new_rec [2];
   logic [1:0]       n_new;
   logic [1:0]       base;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_sw_ff   <= SAMPLE_WIDTH_RESET;
         cfg_thr_ff  <= THRESHOLD_RESET;
         cfg_clip_ff <= CLIP_LEVEL_RESET;
      end else if (csr_port.valid) begin
         case (csr_port.index)
            CSR_SAMPLE_WIDTH: cfg_sw_ff   <= csr_port.data[0];
            CSR_THRESHOLD:    cfg_thr_ff  <= csr_port.data;
            CSR_CLIP_LEVEL:   cfg_clip_ff <= csr_port.data;
            default: ;
         endcase
      end
   end

   // ---------------- magnitude of the registered sample ----------------
   always_comb begin
      logic [15:0] s16;
      logic [16:0] m16;
      s16 = s1_sample_ff[15:0];
      m16 = s16[15] ? (17'd0 - {s16[15], s16}) : {1'b0, s16};
      if (cfg_sw_ff) begin
         // two's complement negate in 25 bits keeps -2^23 as 2^23
         mag_raw = s1_sample_ff[SAMPLE_W-1]
                   ? (25'd0 - {s1_sample_ff[SAMPLE_W-1], s1_sample_ff})
                   : {1'b0, s1_sample_ff};
      end else begin
         mag_raw = {m16, 8'd0};
      end
      if (mag_raw > {2'b00, cfg_clip_ff}) mag = cfg_clip_ff;
      else                                mag = mag_raw[MAG_W-1:0];
   end

   // ---------------- per-channel run logic ----------------
   always_comb begin
      cur = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (i == int'(s1_chan_ff)) cur = state_ff[i];
      end
   end

   assign ch_ok = (int'(s1_chan_ff) < CHANNELS);

   always_comb begin
      record_type zero_rec;
      record_type peak_rec;
      zero_rec = '{out_channel: s1_chan_ff, value: '0, repeat_count: COUNT_W'(1),
                   last: 1'b0};
      peak_rec = zero_rec;
      state_in = cur;
      n_new    = 2'd0;
      new_rec[0] = zero_rec;
      new_rec[1] = zero_rec;

      if (!cur.first_seen) begin
         // first sample of a stream never opens a run
         state_in.first_seen = 1'b1;
         state_in.in_run     = 1'b0;
         n_new = 2'd1;
      end else if (cur.in_run) begin
         if (mag >= cfg_thr_ff) begin
            if (cur.run_length != COUNT_MAX) state_in.run_length = cur.run_length + 1'b1;
            if (mag > cur.run_peak)          state_in.run_peak   = mag;
         end else begin
            // run closed by a low sample: peak record, then a zero for the sample
            peak_rec.value = cfg_sw_ff ? cur.run_peak : (cur.run_peak >> 8);
            peak_rec.repeat_count = cur.run_length;
            new_rec[0] = peak_rec;
            new_rec[1] = zero_rec;
            n_new = 2'd2;
            state_in.in_run     = 1'b0;
            state_in.run_length = '0;
            state_in.run_peak   = '0;
         end
      end else if (mag > cfg_thr_ff) begin
         state_in.in_run     = 1'b1;
         state_in.run_length = COUNT_W'(1);
         state_in.run_peak   = mag;
      end else begin
         n_new = 2'd1;
      end

      if (s1_eos_ff) begin
         if (state_in.in_run) begin
            // flush; an open run here always came with no other record
            peak_rec.value = cfg_sw_ff ? state_in.run_peak : (state_in.run_peak >> 8);
            peak_rec.repeat_count = state_in.run_length;
            new_rec[n_new[0]] = peak_rec;
            n_new = n_new + 2'd1;
         end
         state_in = '0;
      end

      if (!ch_ok) n_new = 2'd0;

      if (n_new == 2'd2)      new_rec[1].last = 1'b1;
      else if (n_new == 2'd1) new_rec[0].last = 1'b1;
   end

   // ---------------- result queue and handshakes ----------------
   assign pop  = (occ_ff != 2'd0) && rsp_port.ready;
   assign base = occ_ff - {1'b0, pop};
   assign go   = s1_valid_ff && ({1'b0, base} + {1'b0, n_new} <= 3'd2);

   assign req_port.ready = !s1_valid_ff || go;
   assign req_take       = req_port.valid && req_port.ready;
   assign s1_valid_in    = req_take || (s1_valid_ff && !go);

   always_comb begin
      recq_in[0] = pop ? recq_ff[1] : recq_ff[0];
      recq_in[1] = recq_ff[1];
      occ_in     = base;
      if (go) begin
         occ_in = base + n_new;
         if (base == 2'd0) begin
            recq_in[0] = new_rec[0];
            recq_in[1] = new_rec[1];
         end else if (base == 2'd1) begin
            recq_in[1] = new_rec[0];
         end
      end
   end

   assign rsp_port.valid        = (occ_ff != 2'd0);
   assign rsp_port.out_channel  = recq_ff[0].out_channel;
   assign rsp_port.value        = recq_ff[0].value;
   assign rsp_port.repeat_count = recq_ff[0].repeat_count;
   assign rsp_port.last         = recq_ff[0].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         occ_ff      <= 2'd0;
         for (int i = 0; i < CHANNELS; i++) state_ff[i] <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         occ_ff      <= occ_in;
         if (go && ch_ok) begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (i == int'(s1_chan_ff)) state_ff[i] <= state_in;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_chan_ff   <= req_port.channel;
         s1_sample_ff <= req_port.sample;
         s1_eos_ff    <= req_port.end_of_stream;
      end
      recq_ff[0] <= recq_in[0];
      recq_ff[1] <= recq_in[1];
   end

endmodule

@@ sv/lpf_checker.sv @@
// Port-level checker for the lobe peak filler, bound to the top level.
// Depends on lpf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpf_checker import lpf_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_out_channel,
   input logic [MAG_W-1:0]   rsp_value,
   input logic [COUNT_W-1:0] rsp_repeat_count,
   input logic               rsp_last
);

   // nothing leaves the block right after a reset cycle
   `ASSERT_ALL(a_idle_after_reset, clock, $past(reset) |-> !rsp_valid, "response valid after reset")

   // every record stands for at least one output sample
   `ASSERT_CLK(a_count_nonzero, clock, reset, rsp_valid |-> rsp_repeat_count != '0, "zero repeat count")

   // a stalled record stays and keeps its payload
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_out_channel, rsp_value, rsp_repeat_count, rsp_last}), "stalled response changed")

endmodule

bind lobe_peak_fill lpf_checker u_lpf_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_port.valid),
   .rsp_ready        (rsp_port.ready),
   .rsp_out_channel  (rsp_port.out_channel),
   .rsp_value        (rsp_port.value),
   .rsp_repeat_count (rsp_port.repeat_count),
   .rsp_last         (rsp_port.last)
);

@@ tb/lpf_record_checker.sv @@
// Record checker for the lobe peak filler: watches all channels, predicts records.
// Depends on lpf_pkg and the interfaces in lpf_if.sv.
`timescale 1ns / 1ps

module lpf_record_checker import lpf_pkg::*; #(
   parameter int CHANNELS = LPF_CHANNELS
) (
   input  logic        clock,
   input  logic        reset,
   lpf_req_if          req,
   lpf_rsp_if          rsp,
   lpf_csr_if          csr,
   output int unsigned mismatches,
   output int unsigned outstanding,
   output int unsigned records_seen
);

   logic             wide;
   logic [MAG_W-1:0] threshold;
   logic [MAG_W-1:0] clip_level;
   chan_state_type   lane [CHANNELS];
   record_type       expected_records [$];

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t ns mismatch: %s got %0d expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         report(what, got, want);
      end
   endtask

   // Magnitude on the 2^23 scale, clipped.
   function automatic logic [MAG_W-1:0] rectify(logic [SAMPLE_W-1:0] s);
      logic [SAMPLE_W:0] m;
      if (wide) begin
         m = s[SAMPLE_W-1] ? (25'h1000000 - {1'b0, s}) : {1'b0, s};
      end else begin
         m = s[15] ? (25'h0010000 - {9'd0, s[15:0]}) : {9'd0, s[15:0]};
         m = m << 8;
      end
      if (m > {2'b00, clip_level}) begin
         m = {2'b00, clip_level};
      end
      return m[MAG_W-1:0];
   endfunction

   function automatic record_type make_record(logic ch, logic [MAG_W-1:0] val,
                                              logic [COUNT_W-1:0] cnt);
      record_type r;
      r.out_channel  = ch;
      r.value        = wide ? val : (val >> 8);
      r.repeat_count = cnt;
      r.last         = 1'b0;
      return r;
   endfunction

   // One accepted sample: update the channel and queue the records it causes.
   task automatic take_sample(logic ch, logic [SAMPLE_W-1:0] s, logic eos);
      logic [MAG_W-1:0] mag;
      record_type       recs [$];
      mag = rectify(s);
      if (!lane[ch].first_seen) begin
         lane[ch].first_seen = 1'b1;
         lane[ch].in_run     = 1'b0;
         recs.push_back(make_record(ch, '0, COUNT_W'(1)));
      end else if (lane[ch].in_run) begin
         if (mag >= threshold) begin
            if (lane[ch].run_length != COUNT_MAX) begin
               lane[ch].run_length++;
            end
            if (mag > lane[ch].run_peak) begin
               lane[ch].run_peak = mag;
            end
         end else begin
            recs.push_back(make_record(ch, lane[ch].run_peak, lane[ch].run_length));
            recs.push_back(make_record(ch, '0, COUNT_W'(1)));
            lane[ch].in_run     = 1'b0;
            lane[ch].run_length = '0;
            lane[ch].run_peak   = '0;
         end
      end else if (mag > threshold) begin
         lane[ch].in_run     = 1'b1;
         lane[ch].run_length = COUNT_W'(1);
         lane[ch].run_peak   = mag;
      end else begin
         recs.push_back(make_record(ch, '0, COUNT_W'(1)));
      end

      if (eos) begin
         if (lane[ch].in_run) begin
            recs.push_back(make_record(ch, lane[ch].run_peak, lane[ch].run_length));
         end
         lane[ch] = '0;
      end

      if (recs.size() > 0) begin
         recs[recs.size()-1].last = 1'b1;
      end
      foreach (recs[i]) begin
         expected_records.push_back(recs[i]);
      end
   endtask

   always @(posedge clock) begin
      record_type want;
      if (reset) begin
         wide       = SAMPLE_WIDTH_RESET;
         threshold  = THRESHOLD_RESET;
         clip_level = CLIP_LEVEL_RESET;
         foreach (lane[i]) begin
            lane[i] = '0;
         end
         expected_records.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr_index_type'(csr.index))
               CSR_SAMPLE_WIDTH: wide       = csr.data[0];
               CSR_THRESHOLD:    threshold  = csr.data[MAG_W-1:0];
               CSR_CLIP_LEVEL:   clip_level = csr.data[MAG_W-1:0];
               default: ;
            endcase
         end
         // responses first: a record never leaves in the cycle its request enters
         if (rsp.valid && rsp.ready) begin
            if (expected_records.size() == 0) begin
               report("record with nothing pending, value", 32'(rsp.value), 32'd0);
            end else begin
               want = expected_records.pop_front();
               records_seen++;
               check_field("out_channel", 32'(rsp.out_channel), 32'(want.out_channel));
               check_field("value", 32'(rsp.value), 32'(want.value));
               check_field("repeat_count", 32'(rsp.repeat_count), 32'(want.repeat_count));
               check_field("last", 32'(rsp.last), 32'(want.last));
            end
         end
         if (req.valid && req.ready) begin
            take_sample(req.channel, req.sample, req.end_of_stream);
         end
      end
      outstanding = expected_records.size();
   end

endmodule

@@ tb/tb.sv @@
// Top of the lobe peak filler testbench: clock, reset, request and register stimulus.
// Depends on lpf_pkg, lpf_if.sv, the block, and lpf_record_checker for prediction.
`timescale 1ns / 1ps

module tb;
   import lpf_pkg::*;

   localparam int          SETTLE_CYCLES  = 4;    // lets a request that yields nothing leave the pipe
   localparam int          TAIL_CYCLES    = 12;
   localparam int          HOLD_CYCLES    = 300;  // long receiver hold-off
   localparam int          WATCHDOG_LIMIT = 3000;
   localparam int          PHASES         = 8;
   localparam int unsigned MAG_MAX        = 2**MAG_W - 1;
   localparam int unsigned FULL_SCALE     = 2**MAG_W;
   // not a register; writes to it must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef enum int unsigned {RX_OPEN, RX_SPARSE, RX_COIN, RX_PERIODIC} rx_mode_type;

   logic clock;
   logic reset;

   lpf_req_if req_if ();
   lpf_rsp_if rsp_if ();
   lpf_csr_if csr_if ();

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned records_seen;

   int unsigned items_sent  = 0;
   int unsigned settings    = 0;
   int unsigned idle_cycles = 0;
   int unsigned burst_left  = 0;
   bit          request_hold = 1'b0;
   bit          hold_done    = 1'b0;

   // shadow of the live register values, used only to shape stimulus
   logic        cur_width = SAMPLE_WIDTH_RESET;
   int unsigned cur_thr   = THRESHOLD_RESET;
   logic        last_ch   = 1'b0;

   lobe_peak_fill #(.CHANNELS(LPF_CHANNELS)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   lpf_record_checker #(.CHANNELS(LPF_CHANNELS)) record_check (
      .clock        (clock),
      .reset        (reset),
      .req          (req_if),
      .rsp          (rsp_if),
      .csr          (csr_if),
      .mismatches   (mismatches),
      .outstanding  (outstanding),
      .records_seen (records_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Handshake helpers. Ready is sampled at the falling edge, where it is stable
   // until the next rising edge; all drives happen at rising edges.
   // ---------------------------------------------------------------------------

   // One register write; the caller drops valid after its last write.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(negedge clock); while (!csr_if.ready);
      @(posedge clock);
   endtask

   // Full register set, written back to back. Width data carries junk above bit 0.
   task automatic set_config(logic w, logic [MAG_W-1:0] thr, logic [MAG_W-1:0] clip,
                             bit spare);
      logic [CSR_DATA_W-1:0] wdata;
      wdata    = CSR_DATA_W'($urandom);
      wdata[0] = w;
      write_reg(CSR_SAMPLE_WIDTH, wdata);
      write_reg(CSR_THRESHOLD, thr);
      if (spare) begin
         write_reg(CSR_SPARE_INDEX, CSR_DATA_W'($urandom));
      end
      write_reg(CSR_CLIP_LEVEL, clip);
      csr_if.valid <= 1'b0;
      cur_width = w;
      cur_thr   = thr;
      settings++;
   endtask

   // Send one request. Sender runs in bursts; a gap may open when a burst runs out.
   task automatic send_item(logic ch, logic [SAMPLE_W-1:0] s, logic eos);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // now and then a long burst with no idling at all
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_if.valid         <= 1'b1;
      req_if.channel       <= ch;
      req_if.sample        <= s;
      req_if.end_of_stream <= eos;
      do @(negedge clock); while (!req_if.ready);
      @(posedge clock);
      items_sent++;
   endtask

   // Stop sending and wait until every expected record is back, then give a
   // request that yields nothing time to leave the pipe.
   task automatic drain();
      req_if.valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sample with a given magnitude and sign at the current width. In 16-bit
   // mode the upper byte may carry junk, which the block must ignore.
   function automatic logic [SAMPLE_W-1:0] sample_for(int unsigned mag, bit neg, bit junk);
      int unsigned      m16;
      logic [15:0]      v16;
      logic [SAMPLE_W-1:0] v24;
      logic [7:0]       upper;
      if (cur_width) begin
         if (mag >= FULL_SCALE) begin
            mag = FULL_SCALE;
            neg = 1'b1;
         end
         v24 = mag[SAMPLE_W-1:0];
         if (neg) v24 = -v24;
         return v24;
      end
      m16 = (mag + 255) >> 8;
      if (m16 >= 32768) begin
         m16 = 32768;
         neg = 1'b1;
      end
      v16 = m16[15:0];
      if (neg) v16 = -v16;
      upper = junk ? 8'($urandom) : {8{v16[15]}};
      return {upper, v16};
   endfunction

   // Random request, biased to build runs: above, at and below threshold.
   task automatic send_random();
      int unsigned pick;
      int unsigned mag;
      int unsigned hi;
      logic [SAMPLE_W-1:0] s;
      // channels mostly stick, so runs get long enough to matter
      if ($urandom_range(0, 9) < 3) last_ch = ~last_ch;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         hi  = cur_thr + 1 + $urandom_range(0, MAG_MAX - cur_thr);
         mag = $urandom_range(cur_thr + 1, hi);
      end else if (pick < 55) begin
         mag = cur_thr;
      end else if (pick < 85) begin
         mag = (cur_thr == 0) ? 0 : $urandom_range(0, cur_thr - 1);
      end else begin
         mag = FULL_SCALE + 1;        // marker: fully random bits
      end
      if (mag > FULL_SCALE) begin
         s = SAMPLE_W'($urandom);
      end else begin
         s = sample_for(mag, $urandom_range(0, 1), $urandom_range(0, 3) == 0);
      end
      send_item(last_ch, s, $urandom_range(0, 24) == 0);
   endtask

   // ---------------------------------------------------------------------------
   // Receiver: segments of different stall patterns, plus one long hold-off
   // on request, counted here, while the sender keeps offering requests.
   // ---------------------------------------------------------------------------
   initial begin
      rx_mode_type mode;
      int unsigned seg_left;
      int unsigned hold_left;
      int unsigned tick;
      seg_left  = 0;
      hold_left = 0;
      tick      = 0;
      mode      = RX_OPEN;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
            if (hold_left == 0) hold_done = 1'b1;
         end else if (request_hold && !hold_done) begin
            hold_left = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               mode     = rx_mode_type'($urandom_range(0, 3));
               seg_left = $urandom_range(10, 80);
            end
            seg_left--;
            case (mode)
               RX_OPEN:     rsp_if.ready <= 1'b1;
               RX_SPARSE:   rsp_if.ready <= ($urandom_range(0, 3) == 0);
               RX_COIN:     rsp_if.ready <= $urandom_range(0, 1);
               RX_PERIODIC: rsp_if.ready <= ((tick % 4) != 3);
               default:     rsp_if.ready <= 1'b1;
            endcase
         end
      end
   end

   // Watchdog: too long without any handshake ends the run.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d records outstanding",
                  idle_cycles, outstanding);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin
      int unsigned n_items;
      int unsigned thr;
      int unsigned clip;
      logic        w;

      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.channel       <= 1'b0;
      req_if.sample        <= '0;
      req_if.end_of_stream <= 1'b0;
      csr_if.valid         <= 1'b0;
      csr_if.index         <= CSR_SAMPLE_WIDTH;
      csr_if.data          <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset registers: 24-bit, threshold 83886, clip 8371830.
      send_item(1'b0, 24'd0, 1'b0);             // stream opener, zero record
      send_item(1'b0, 24'd100000, 1'b0);        // run starts, nothing out
      send_item(1'b0, 24'h800000, 1'b0);        // most negative, clipped, run grows
      send_item(1'b0, 24'd83886, 1'b0);         // at threshold keeps the run
      send_item(1'b0, 24'd5, 1'b0);             // run ends: peak record then zero
      send_item(1'b0, 24'd83886, 1'b0);         // at threshold does not start one
      send_item(1'b1, 24'h7FFFFF, 1'b1);        // opener and end of stream at once
      send_item(1'b1, -24'sd200000, 1'b0);      // reopened stream: zero again
      send_item(1'b1, 24'd200000, 1'b0);        // run start
      send_item(1'b1, -24'sd300000, 1'b1);      // end of stream flushes open run
      send_item(1'b0, 24'd90000, 1'b0);         // run start
      send_item(1'b0, 24'd0, 1'b1);             // run ends on the stream's last sample
      send_item(1'b0, 24'd90000, 1'b1);         // reopened and closed at once
      drain();

      // Directed, 16-bit mode: only the low half counts, upper byte is junk.
      set_config(1'b0, 23'd100000, MAG_W'(MAG_MAX), 1'b1);
      send_item(1'b0, 24'hFF7FFF, 1'b0);        // opener
      send_item(1'b0, 24'h008000, 1'b0);        // -32768 reaches full scale
      send_item(1'b0, 24'h00FFFF, 1'b0);        // -1: below, peak leaves as 32767
      send_item(1'b1, 24'hA57FFF, 1'b1);        // largest positive, end of stream
      drain();

      // Random phases: register extremes first, then random settings.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: set_config(1'b0, '0, MAG_W'(MAG_MAX), 1'b0);             // runs never end early
            1: set_config(1'b1, MAG_W'(MAG_MAX), MAG_W'(MAG_MAX), 1'b0); // no run can start
            2: set_config(1'b0, MAG_W'(MAG_MAX), '0, 1'b0);             // everything clipped to 0
            default: begin
               w    = (p % 2 == 0);
               thr  = $urandom_range(0, 1) ? $urandom_range(2000, 400000)
                                           : $urandom_range(0, MAG_MAX);
               clip = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAG_MAX)
                                                  : $urandom_range(thr, MAG_MAX);
               set_config(w, MAG_W'(thr), MAG_W'(clip), $urandom_range(0, 1));
            end
         endcase
         n_items = (p < 3) ? 25 : 75;
         for (int k = 0; k < n_items; k++) begin
            // back up the result path once, mid-phase, while requests keep coming
            if (p == 4 && k == 10) request_hold = 1'b1;
            send_random();
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d samples over %0d register settings, both widths and both channels",
               items_sent, settings);
      $display("%0d records compared, one %0d-cycle receiver hold-off to back up requests",
               records_seen, HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
